// File: sv/cde_pkg.sv
// shared types and constants for the colour-distance edge detector
// no dependencies; every other file refers to it by scoped names
`default_nettype none

package cde_pkg;

  localparam int MAX_LINE_PIXELS = 1024;
  localparam int ADDR_W          = $clog2(MAX_LINE_PIXELS);
  localparam int MAX_LINES       = 4096;

  localparam int COMP_W     = 8;
  localparam int COL_W      = 10;
  localparam int ROW_W      = 12;
  localparam int WIDTH_W    = 11;
  localparam int HEIGHT_W   = 13;
  localparam int THR_W      = 9;
  localparam int SQ_W       = 2 * COMP_W;
  localparam int DIST_W     = SQ_W + 2;
  localparam int THR_SQ_W   = 2 * THR_W;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 13;

  localparam int FIFO_DEPTH = 8;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = FIFO_PTR_W + 1;

  localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(120);
  localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(68);
  localparam logic [THR_W-1:0]    THR_RESET    = THR_W'(35);
  localparam logic [THR_SQ_W-1:0] THR_SQ_RESET = THR_SQ_W'(35 * 35);

  localparam logic [WIDTH_W-1:0]  WIDTH_MIN  = WIDTH_W'(3);
  localparam logic [WIDTH_W-1:0]  WIDTH_MAX  = WIDTH_W'(MAX_LINE_PIXELS);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MIN = HEIGHT_W'(3);
  localparam logic [HEIGHT_W-1:0] HEIGHT_MAX = HEIGHT_W'(MAX_LINES);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_IMAGE_WIDTH          = 2'd0,
    REG_IMAGE_HEIGHT         = 2'd1,
    REG_SIMILARITY_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic [COMP_W-1:0] red;
    logic [COMP_W-1:0] green;
    logic [COMP_W-1:0] blue;
  } pixel_t;

  typedef struct packed {
    logic [COL_W-1:0] col;
    logic [ROW_W-1:0] row;
  } position_t;

  typedef struct packed {
    position_t pos;
    pixel_t    color;
    logic      is_edge;
  } result_t;

  typedef struct packed {
    logic              en;
    logic [ADDR_W-1:0] addr;
    pixel_t            above;
    pixel_t            two_above;
  } ls_write_t;

endpackage

`default_nettype wire

// File: sv/cde_ifs.sv
// valid/ready channel interfaces: pixel stream, result stream, register writes
// depends on cde_pkg for field widths
`default_nettype none

interface cde_pixel_if;
  logic                       valid;
  logic                       ready;
  logic                       frame_start;
  logic [cde_pkg::COMP_W-1:0] pixel_red;
  logic [cde_pkg::COMP_W-1:0] pixel_green;
  logic [cde_pkg::COMP_W-1:0] pixel_blue;

  modport source (output valid, frame_start, pixel_red, pixel_green, pixel_blue,
                  input ready);
  modport sink (input valid, frame_start, pixel_red, pixel_green, pixel_blue,
                output ready);
endinterface

interface cde_result_if;
  logic                       valid;
  logic                       ready;
  logic [cde_pkg::COL_W-1:0]  center_column;
  logic [cde_pkg::ROW_W-1:0]  center_row;
  logic [cde_pkg::COMP_W-1:0] center_red;
  logic [cde_pkg::COMP_W-1:0] center_green;
  logic [cde_pkg::COMP_W-1:0] center_blue;
  logic                       is_edge;

  modport source (output valid, center_column, center_row, center_red, center_green,
                  center_blue, is_edge, input ready);
  modport sink (input valid, center_column, center_row, center_red, center_green,
                center_blue, is_edge, output ready);
endinterface

interface cde_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [cde_pkg::CFG_IDX_W-1:0]  index;
  logic [cde_pkg::CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: sv/cde_line_store.sv
// two line memories (line above, line two above) with registered reads
// and write-to-read forwarding; depends on cde_pkg
`default_nettype none

module cde_line_store (
  input  logic                       clk,
  input  logic                       rd_en,
  input  logic [cde_pkg::ADDR_W-1:0] rd_addr,
  input  cde_pkg::ls_write_t         wr,
  output cde_pkg::pixel_t            center,
  output cde_pkg::pixel_t            right,
  output cde_pkg::pixel_t            top
);

  cde_pkg::pixel_t above_mem [cde_pkg::MAX_LINE_PIXELS];
  cde_pkg::pixel_t two_mem [cde_pkg::MAX_LINE_PIXELS];

  cde_pkg::pixel_t             center_rd;
  cde_pkg::pixel_t             right_rd;
  cde_pkg::pixel_t             top_rd;
  cde_pkg::pixel_t             fwd_above;
  cde_pkg::pixel_t             fwd_two;
  logic                        fwd_center;
  logic                        fwd_right;
  logic [cde_pkg::ADDR_W-1:0]  right_addr;

  assign right_addr = rd_addr + 1'b1;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      above_mem[wr.addr] <= wr.above;
      two_mem[wr.addr]   <= wr.two_above;
    end
  end

  // a write landing on the same edge as a read is forwarded
  always_ff @(posedge clk) begin
    if (rd_en) begin
      center_rd  <= above_mem[rd_addr];
      right_rd   <= above_mem[right_addr];
      top_rd     <= two_mem[rd_addr];
      fwd_center <= wr.en && (wr.addr == rd_addr);
      fwd_right  <= wr.en && (wr.addr == right_addr);
      fwd_above  <= wr.above;
      fwd_two    <= wr.two_above;
    end
  end

  assign center = fwd_center ? fwd_above : center_rd;
  assign top    = fwd_center ? fwd_two   : top_rd;
  assign right  = fwd_right  ? fwd_above : right_rd;

endmodule

`default_nettype wire

// File: sv/cde_dist.sv
// two-stage colour distance judge: squared differences, then sums and threshold
// compare over the four neighbours; depends on cde_pkg
`default_nettype none

module cde_dist (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  cde_pkg::position_t           in_pos,
  input  cde_pkg::pixel_t              center,
  input  cde_pkg::pixel_t              left,
  input  cde_pkg::pixel_t              right,
  input  cde_pkg::pixel_t              top,
  input  cde_pkg::pixel_t              bottom,
  input  logic [cde_pkg::THR_SQ_W-1:0] thresh_sq,
  output logic                         out_valid,
  output cde_pkg::result_t             out_result,
  output logic [1:0]                   stage_count
);

  function automatic logic [cde_pkg::SQ_W-1:0] sq_diff(
    input logic [cde_pkg::COMP_W-1:0] a,
    input logic [cde_pkg::COMP_W-1:0] b
  );
    logic [cde_pkg::COMP_W-1:0] d;
    d = (a > b) ? a - b : b - a;
    return cde_pkg::SQ_W'(d) * cde_pkg::SQ_W'(d);
  endfunction

  cde_pkg::pixel_t           nb [4];
  logic [cde_pkg::SQ_W-1:0]  sq_next [4][3];
  logic [cde_pkg::SQ_W-1:0]  a_sq [4][3];
  logic                      a_valid;
  cde_pkg::position_t        a_pos;
  cde_pkg::pixel_t           a_color;
  logic [cde_pkg::DIST_W-1:0] sum_sq [4];
  logic                      edge_next;

  assign nb[0] = left;
  assign nb[1] = right;
  assign nb[2] = top;
  assign nb[3] = bottom;

  always_comb begin
    for (int n = 0; n < 4; n++) begin
      sq_next[n][0] = sq_diff(center.red,   nb[n].red);
      sq_next[n][1] = sq_diff(center.green, nb[n].green);
      sq_next[n][2] = sq_diff(center.blue,  nb[n].blue);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    a_sq    <= sq_next;
    a_pos   <= in_pos;
    a_color <= center;
  end

  // edge when any neighbour sits at or beyond the threshold
  always_comb begin
    edge_next = 1'b0;
    for (int n = 0; n < 4; n++) begin
      sum_sq[n] = cde_pkg::DIST_W'(a_sq[n][0]) + cde_pkg::DIST_W'(a_sq[n][1])
                + cde_pkg::DIST_W'(a_sq[n][2]);
      if (sum_sq[n] >= thresh_sq) begin
        edge_next = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    out_result.pos     <= a_pos;
    out_result.color   <= a_color;
    out_result.is_edge <= edge_next;
  end

  assign stage_count = {1'b0, a_valid} + {1'b0, out_valid};

endmodule

`default_nettype wire

// File: sv/cde_fifo.sv
// small result queue in front of the output channel
// depends on cde_pkg for the result type and depth
`default_nettype none

module cde_fifo (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           push,
  input  cde_pkg::result_t               push_data,
  input  logic                           pop,
  output cde_pkg::result_t               head,
  output logic [cde_pkg::FIFO_CNT_W-1:0] count
);

  cde_pkg::result_t                mem [cde_pkg::FIFO_DEPTH];
  logic [cde_pkg::FIFO_PTR_W-1:0]  wr_ptr;
  logic [cde_pkg::FIFO_PTR_W-1:0]  rd_ptr;

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  assign head = mem[rd_ptr];

endmodule

`default_nettype wire

// File: sv/color_distance_edge_detector.sv
// Four-neighbour colour-distance edge detector over a raster RGB pixel stream.
// Takes one pixel per clock while the result queue has room; the pixel stream
// stalls only when the eight-entry result queue plus the judgements still in
// flight would fill it. A result reaches the queue after the pixel below its
// center is taken, through the line memory read, squared differences, and sums
// and compare, and leaves the queue when the output takes it. The line memories
// hold 1024 pixels of the two previous lines, read at the current and the next
// column in the same cycle; they need no clearing after reset, but the first
// two lines after a reset or a width change are only meaningful once fully written.
// depends on cde_pkg, cde_ifs, cde_line_store, cde_dist and cde_fifo
`default_nettype none

module color_distance_edge_detector (
  input  logic       clk,
  input  logic       rst,
  cde_pixel_if.sink  pixels,
  cde_result_if.source results,
  cde_cfg_if.sink    cfg
);

  logic [cde_pkg::WIDTH_W-1:0]  image_width;
  logic [cde_pkg::HEIGHT_W-1:0] image_height;
  logic [cde_pkg::THR_W-1:0]    similarity_threshold;
  logic [cde_pkg::THR_SQ_W-1:0] thresh_sq;
  logic [cde_pkg::WIDTH_W-1:0]  w_use;
  logic [cde_pkg::HEIGHT_W-1:0] h_use;

  logic [cde_pkg::COL_W-1:0]    column_count;
  logic [cde_pkg::ROW_W-1:0]    row_count;
  logic [cde_pkg::COL_W-1:0]    col_cur;
  logic [cde_pkg::ROW_W-1:0]    row_cur;
  logic [cde_pkg::WIDTH_W-1:0]  col_inc;
  logic [cde_pkg::HEIGHT_W-1:0] row_inc;
  logic [cde_pkg::ROW_W-1:0]    row_wrap;
  logic                         past_line;
  logic                         line_end;
  logic                         emit;
  logic                         accept;
  logic                         cfg_write;

  logic                         s1_valid;
  logic                         s1_store;
  logic                         s1_emit;
  cde_pkg::position_t           s1_pos;
  cde_pkg::pixel_t              s1_pix;
  cde_pkg::pixel_t              previous_pixel;

  cde_pkg::pixel_t              center;
  cde_pkg::pixel_t              right;
  cde_pkg::pixel_t              top;
  cde_pkg::ls_write_t           ls_wr;

  logic                         dist_valid;
  cde_pkg::result_t             dist_result;
  logic [1:0]                   stage_count;
  logic [1:0]                   inflight;
  logic [cde_pkg::FIFO_CNT_W-1:0] fifo_count;
  logic [cde_pkg::FIFO_CNT_W:0] occupancy;
  cde_pkg::result_t             head;
  logic                         pop;

  // register writes
  assign cfg.ready = 1'b1;
  assign cfg_write = cfg.valid && cfg.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width          <= cde_pkg::WIDTH_RESET;
      image_height         <= cde_pkg::HEIGHT_RESET;
      similarity_threshold <= cde_pkg::THR_RESET;
    end else if (cfg_write) begin
      unique case (cde_pkg::cfg_reg_t'(cfg.index))
        cde_pkg::REG_IMAGE_WIDTH:
          image_width <= cfg.data[cde_pkg::WIDTH_W-1:0];
        cde_pkg::REG_IMAGE_HEIGHT:
          image_height <= cfg.data[cde_pkg::HEIGHT_W-1:0];
        cde_pkg::REG_SIMILARITY_THRESHOLD:
          similarity_threshold <= cfg.data[cde_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh_sq <= cde_pkg::THR_SQ_RESET;
    end else begin
      thresh_sq <= cde_pkg::THR_SQ_W'(similarity_threshold) *
                   cde_pkg::THR_SQ_W'(similarity_threshold);
    end
  end

  always_comb begin
    priority if (image_width < cde_pkg::WIDTH_MIN) begin
      w_use = cde_pkg::WIDTH_MIN;
    end else if (image_width > cde_pkg::WIDTH_MAX) begin
      w_use = cde_pkg::WIDTH_MAX;
    end else begin
      w_use = image_width;
    end
  end

  always_comb begin
    priority if (image_height < cde_pkg::HEIGHT_MIN) begin
      h_use = cde_pkg::HEIGHT_MIN;
    end else if (image_height > cde_pkg::HEIGHT_MAX) begin
      h_use = cde_pkg::HEIGHT_MAX;
    end else begin
      h_use = image_height;
    end
  end

  // position of the incoming beat
  assign accept    = pixels.valid && pixels.ready;
  assign col_cur   = pixels.frame_start ? '0 : column_count;
  assign row_cur   = pixels.frame_start ? '0 : row_count;
  assign col_inc   = {1'b0, col_cur} + 1'b1;
  assign row_inc   = {1'b0, row_cur} + 1'b1;
  assign row_wrap  = (row_inc >= h_use) ? '0 : row_inc[cde_pkg::ROW_W-1:0];
  assign past_line = {1'b0, col_cur} >= w_use;
  assign line_end  = past_line || (col_inc >= w_use);
  assign emit      = !line_end && (row_cur >= cde_pkg::ROW_W'(2)) && (col_cur != '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (line_end) begin
        column_count <= '0;
        row_count    <= row_wrap;
      end else begin
        column_count <= col_inc[cde_pkg::COL_W-1:0];
        row_count    <= row_cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_store   <= !past_line;
      s1_emit    <= emit;
      s1_pos.col <= col_cur;
      s1_pos.row <= row_cur - 1'b1;
      s1_pix     <= '{red: pixels.pixel_red, green: pixels.pixel_green,
                      blue: pixels.pixel_blue};
    end
  end

  cde_line_store u_line_store (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (col_cur[cde_pkg::ADDR_W-1:0]),
    .wr      (ls_wr),
    .center  (center),
    .right   (right),
    .top     (top)
  );

  // center moves down one line, the new pixel takes its place
  assign ls_wr.en        = s1_valid && s1_store;
  assign ls_wr.addr      = s1_pos.col[cde_pkg::ADDR_W-1:0];
  assign ls_wr.above     = s1_pix;
  assign ls_wr.two_above = center;

  always_ff @(posedge clk) begin
    if (rst) begin
      previous_pixel <= '0;
    end else if (ls_wr.en) begin
      previous_pixel <= center;
    end
  end

  cde_dist u_dist (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s1_valid && s1_emit),
    .in_pos      (s1_pos),
    .center      (center),
    .left        (previous_pixel),
    .right       (right),
    .top         (top),
    .bottom      (s1_pix),
    .thresh_sq   (thresh_sq),
    .out_valid   (dist_valid),
    .out_result  (dist_result),
    .stage_count (stage_count)
  );

  // credit check: every judgement in flight has a queue slot waiting
  assign inflight  = {1'b0, s1_valid && s1_emit} + stage_count;
  assign occupancy = {1'b0, fifo_count} + (cde_pkg::FIFO_CNT_W + 1)'(inflight);
  assign pixels.ready = occupancy < (cde_pkg::FIFO_CNT_W + 1)'(cde_pkg::FIFO_DEPTH);

  assign pop = results.valid && results.ready;

  cde_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (dist_valid),
    .push_data (dist_result),
    .pop       (pop),
    .head      (head),
    .count     (fifo_count)
  );

  assign results.valid         = fifo_count != '0;
  assign results.center_column = head.pos.col;
  assign results.center_row    = head.pos.row;
  assign results.center_red    = head.color.red;
  assign results.center_green  = head.color.green;
  assign results.center_blue   = head.color.blue;
  assign results.is_edge       = head.is_edge;

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    occupancy <= (cde_pkg::FIFO_CNT_W + 1)'(cde_pkg::FIFO_DEPTH))
    else $error("result queue overrun");

  a_judge_reaches_queue: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s1_emit) |-> ##2 dist_valid)
    else $error("judged pixel lost before queue");

  a_interior_only: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.center_column != '0) && (results.center_row != '0))
    else $error("border pixel reported");
`endif

endmodule

`default_nettype wire
